// ===== rtl/ring_buffer_engine_defines.svh =====
// ----------------------------------------------------------------------------
// ring buffer engine assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_ENGINE_DEFINES_SVH
`define RING_BUFFER_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RBE_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring buffer engine check failed");

// next-cycle implication
`define RBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring buffer engine check failed");

`else

`define RBE_ASSERT_IMPLIES(label, ante, cons)
`define RBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// shared types and constants of the ring buffer engine
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

    localparam int DEPTH_DEF      = 4096;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int IO_DATA_W = 32;
    localparam int OPND_W    = 13;
    localparam int FILL_W    = 13;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DROP  = 3'd3,
        CMD_ERASE = 3'd4,
        CMD_CLEAR = 3'd5,
        CMD_READ  = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_FEW   = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/ring_buffer_engine.sv =====
// ring_buffer_engine: circular buffer of DEPTH words with status per command
// done: push, drop, clear and rejected commands answer in the cycle after start;
//          pop, peek, read offset and erase answer after passing the read or erase state
// throughput: 1 command per cycle while not busy; commands that read storage hold busy
//          through the read or erase state, set by the single port of the storage ram
// reset: read pointer and count cleared, write pointer set to DEPTH-1, storage not cleared; done cannot be stalled
`default_nettype none

`include "ring_buffer_engine_defines.svh"

// ----------------------------------------------------------------------------
// ring_buffer_engine
// command-driven circular buffer fifo: push, pop, peek, drop, erase, clear
// and indexed read over one synchronous storage ram
// ----------------------------------------------------------------------------
module ring_buffer_engine
    import rbe_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [IO_DATA_W-1:0] data_in,
    input  wire logic [OPND_W-1:0]    operand,
    output logic                      busy,
    output logic                      done,
    output logic      [IO_DATA_W-1:0] data_out,
    output logic      [FILL_W-1:0]    fill_count,
    output logic      [STAT_W-1:0]    status
);

    // pointer and count widths follow the depth
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for compares and wrapped sums (up to 2*DEPTH-1)
    localparam int CMP_W = (OPND_W > CNT_W + 1) ? OPND_W : CNT_W + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ERASE
    } state_t;

    state_t                  state_reg;
    logic    [PTR_W-1:0]     rp_reg, rp_next;
    logic    [PTR_W-1:0]     wp_reg, wp_next;
    logic    [CNT_W-1:0]     count_reg, count_next;
    logic                    done_reg;
    logic    [IO_DATA_W-1:0] data_out_reg;
    status_t                 status_reg;
    status_t                 stat_next;
    logic    [PTR_W-1:0]     slot_reg;

    // storage ram port
    logic                    mem_we;
    logic    [PTR_W-1:0]     mem_addr;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic [DATA_WIDTH-1:0]   mem_rdata;

    logic                    accept;
    logic                    go_read;
    logic                    go_erase;

    // widened copies for arithmetic
    logic    [CMP_W-1:0]     opnd_x, cnt_x, rp_x, wp_x;
    logic    [CMP_W-1:0]     wp_inc, wp_dec, rp_inc, rp_drop, rd_slot, erase_rel;
    logic    [CMP_W-1:0]     newest_chk;

    // sum of two values below DEPTH (or one at DEPTH) folded back into range
    function automatic logic [CMP_W-1:0] wrap_add(input logic [CMP_W-1:0] a,
                                                   input logic [CMP_W-1:0] b);
        logic [CMP_W-1:0] sum;
        sum = a + b;
        if (sum >= DEPTH_C)
        begin
            sum = sum - DEPTH_C;
        end
        return sum;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);

    assign opnd_x = CMP_W'(operand);
    assign cnt_x  = CMP_W'(count_reg);
    assign rp_x   = CMP_W'(rp_reg);
    assign wp_x   = CMP_W'(wp_reg);

    assign wp_inc    = wrap_add(wp_x, CMP_W'(1));
    assign wp_dec    = wrap_add(wp_x, DEPTH_C - CMP_W'(1));
    assign rp_inc    = wrap_add(rp_x, CMP_W'(1));
    assign rp_drop   = wrap_add(rp_x, opnd_x);
    assign rd_slot   = wrap_add(rp_x, opnd_x);
    // distance of the erase slot from the oldest element
    assign erase_rel = wrap_add(opnd_x, DEPTH_C - rp_x);
    // newest slot as derived from read pointer and count
    assign newest_chk = wrap_add(rp_x, wrap_add(cnt_x, DEPTH_C - CMP_W'(1)));

    // command decode, checks and ram port
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        stat_next  = STAT_OK;
        mem_we     = 1'b0;
        mem_addr   = wp_reg;
        mem_wdata  = DATA_WIDTH'(data_in);
        go_read    = 1'b0;
        go_erase   = 1'b0;

        if (state_reg == ST_ERASE)
        begin
            // newest word lands in the erased slot, newest entry dropped
            mem_we     = 1'b1;
            mem_addr   = slot_reg;
            mem_wdata  = mem_rdata;
            wp_next    = PTR_W'(wp_dec);
            count_next = count_reg - CNT_W'(1);
        end
        else if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_PUSH:
                begin
                    if (cnt_x == DEPTH_C)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = PTR_W'(wp_inc);
                        wp_next    = PTR_W'(wp_inc);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (cnt_x == '0)
                    begin
                        stat_next = STAT_FEW;
                    end
                    else
                    begin
                        mem_addr   = rp_reg;
                        go_read    = 1'b1;
                        rp_next    = PTR_W'(rp_inc);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_PEEK:
                begin
                    if (cnt_x == '0)
                    begin
                        stat_next = STAT_FEW;
                    end
                    else
                    begin
                        mem_addr = wp_reg;
                        go_read  = 1'b1;
                    end
                end
                CMD_DROP:
                begin
                    if (opnd_x > cnt_x)
                    begin
                        stat_next = STAT_FEW;
                    end
                    else
                    begin
                        rp_next    = PTR_W'(rp_drop);
                        count_next = CNT_W'(cnt_x - opnd_x);
                    end
                end
                CMD_ERASE:
                begin
                    if (cnt_x == '0)
                    begin
                        stat_next = STAT_FEW;
                    end
                    else if ((opnd_x >= DEPTH_C) || (erase_rel >= cnt_x))
                    begin
                        stat_next = STAT_RANGE;
                    end
                    else
                    begin
                        mem_addr = wp_reg;
                        go_erase = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    rp_next    = '0;
                    wp_next    = PTR_W'(DEPTH_C - CMP_W'(1));
                    count_next = '0;
                end
                CMD_READ:
                begin
                    if (opnd_x >= cnt_x)
                    begin
                        stat_next = STAT_RANGE;
                    end
                    else
                    begin
                        mem_addr = PTR_W'(rd_slot);
                        go_read  = 1'b1;
                    end
                end
                default:
                begin
                    // unused code: no change, status ok
                end
            endcase
        end
    end

    // state, pointers and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            wp_reg       <= PTR_W'(DEPTH_C - CMP_W'(1));
            count_reg    <= '0;
            done_reg     <= 1'b0;
            data_out_reg <= '0;
            status_reg   <= STAT_OK;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        if (go_read)
                        begin
                            state_reg <= ST_READ;
                        end
                        else if (go_erase)
                        begin
                            state_reg <= ST_ERASE;
                        end
                        else
                        begin
                            done_reg     <= 1'b1;
                            data_out_reg <= '0;
                            status_reg   <= stat_next;
                        end
                    end
                end
                ST_READ:
                begin
                    // ram data from the address issued at accept
                    state_reg    <= ST_IDLE;
                    done_reg     <= 1'b1;
                    data_out_reg <= IO_DATA_W'(mem_rdata);
                    status_reg   <= STAT_OK;
                end
                ST_ERASE:
                begin
                    state_reg    <= ST_IDLE;
                    done_reg     <= 1'b1;
                    data_out_reg <= '0;
                    status_reg   <= STAT_OK;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    // erase target slot, held for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= PTR_W'(opnd_x);
        end
    end

    // storage: one access per cycle, so a write and a later read of the same
    // slot never share a cycle and no forwarding is needed
    rbe_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign data_out   = data_out_reg;
    assign fill_count = FILL_W'(count_reg);
    assign status     = status_reg;

    // write pointer always tracks the newest element
    `RBE_ASSERT_IMPLIES(a_wp_consistent, !busy, wp_x == newest_chk)
    // a storage read finishes with an ok result after the read state
    `RBE_ASSERT_NEXT(a_read_done, $past(accept && go_read), done_reg && status_reg == STAT_OK)
    // full is only reported when the buffer holds DEPTH words
    `RBE_ASSERT_IMPLIES(a_full_count, done_reg && status_reg == STAT_FULL, cnt_x == DEPTH_C)
    // a multi-cycle command leaves the read or erase state for idle with done set
    `RBE_ASSERT_NEXT(a_busy_one, busy, !busy && done_reg)

endmodule

`default_nettype wire

// ===== rtl/rbe_ram.sv =====
// ----------------------------------------------------------------------------
// rbe_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire
